// ===== rtl/core/smq_pkg.sv =====
package smq_pkg;

   localparam int NUM_SLOTS_DEF   = 16;
   localparam int NUM_QUEUES_DEF  = 4;
   localparam int DATA_WIDTH_DEF  = 32;

   localparam int VALUE_WIDTH     = 32;
   localparam int QID_WIDTH       = 2;
   localparam int STATUS_WIDTH    = 2;
   localparam int REQ_TDATA_WIDTH = 40;
   localparam int RSP_TDATA_WIDTH = 32;

   localparam int FIFO_DEPTH      = 2;
   localparam int MAX_OUTSTANDING = 4;

   typedef enum logic [0:0] {
      MODE_ENQ = 1'b0,
      MODE_DEQ = 1'b1
   } mode_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      mode_type               mode;
      logic                   qid_ok;
      logic [QID_WIDTH-1:0]   queue_id;
      logic [VALUE_WIDTH-1:0] value;
   } op_type;

endpackage

// ===== rtl/core/shared_buffer_multi_queue.sv =====
// an item passes the fifo, the back end's op register, then the result register
// the back end takes one item at a time: it reads then updates the slot link table
// a two-entry queue between front and back lets req_ take items while a result waits
// reset: synchronous, active high; all queues empty and every slot free at once,
// no clearing pass since never-used slots are handed out by a fill counter
module shared_buffer_multi_queue #(
   parameter int NUM_SLOTS  = smq_pkg::NUM_SLOTS_DEF,
   parameter int NUM_QUEUES = smq_pkg::NUM_QUEUES_DEF,
   parameter int DATA_WIDTH = smq_pkg::DATA_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // queue_id [1:0], value [33:2], zero [39:34]
   input  logic [smq_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   // mode [0]
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // data_out [31:0]
   output logic [smq_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,
   // status [1:0]
   output logic [smq_pkg::STATUS_WIDTH-1:0]    rsp_tuser
);
   import smq_pkg::*;

   logic   fifo_full, push, pop_valid, pop;
   op_type push_op, pop_op;

   smq_front #(
      .NUM_QUEUES (NUM_QUEUES)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .fifo_full  (fifo_full),
      .push       (push),
      .push_op    (push_op)
   );

   smq_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_op   (push_op),
      .full      (fifo_full),
      .pop_valid (pop_valid),
      .pop       (pop),
      .pop_op    (pop_op)
   );

   smq_back #(
      .NUM_SLOTS  (NUM_SLOTS),
      .NUM_QUEUES (NUM_QUEUES),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_op     (pop_op),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== rtl/core/smq_front.sv =====
module smq_front #(
   parameter int NUM_QUEUES = smq_pkg::NUM_QUEUES_DEF
) (
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [smq_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   input  logic                                req_tuser,
   input  logic                                fifo_full,
   output logic                                push,
   output smq_pkg::op_type                     push_op
);
   import smq_pkg::*;

   logic [QID_WIDTH-1:0] queue_id;

   assign queue_id   = req_tdata[QID_WIDTH-1:0];
   assign req_tready = !fifo_full;
   assign push       = req_tvalid && !fifo_full;

   // classify: operation kind and whether the queue number exists
   always_comb begin
      push_op          = '0;
      push_op.mode     = mode_type'(req_tuser);
      push_op.queue_id = queue_id;
      push_op.qid_ok   = int'(queue_id) < NUM_QUEUES;
      push_op.value    = req_tdata[QID_WIDTH +: VALUE_WIDTH];
   end

endmodule

// ===== rtl/core/smq_fifo.sv =====
module smq_fifo (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  smq_pkg::op_type push_op,
   output logic            full,
   output logic            pop_valid,
   input  logic            pop,
   output smq_pkg::op_type pop_op
);
   import smq_pkg::*;

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   op_type           mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = count_ff == CNT_W'(FIFO_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_op    = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ===== rtl/core/smq_back.sv =====
module smq_back #(
   parameter int NUM_SLOTS  = smq_pkg::NUM_SLOTS_DEF,
   parameter int NUM_QUEUES = smq_pkg::NUM_QUEUES_DEF,
   parameter int DATA_WIDTH = smq_pkg::DATA_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                pop_valid,
   output logic                                pop,
   input  smq_pkg::op_type                     pop_op,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [smq_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,
   output logic [smq_pkg::STATUS_WIDTH-1:0]    rsp_tuser
);
   import smq_pkg::*;

   localparam int SLOT_W  = $clog2(NUM_SLOTS);
   localparam int PTR_W   = $clog2(NUM_SLOTS + 1);
   localparam int QUEUE_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(NUM_SLOTS);

   typedef enum logic [1:0] {
      BK_IDLE = 2'b01,
      BK_DONE = 2'b10
   } bk_state_type;

   // slot store and link table
   logic [DATA_WIDTH-1:0] data_mem [NUM_SLOTS];
   logic [PTR_W-1:0]      next_mem [NUM_SLOTS];
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic [PTR_W-1:0]      rd_next_ff;

   // per-queue pointers
   logic [NUM_QUEUES-1:0] nonempty_ff, nonempty_in;
   logic [SLOT_W-1:0]     head_ff [NUM_QUEUES];
   logic [SLOT_W-1:0]     tail_ff [NUM_QUEUES];

   // recycled slots plus a count of never-used slots
   logic [PTR_W-1:0] free_head_ff, free_head_in;
   logic [PTR_W-1:0] fill_ff, fill_in;

   bk_state_type state_ff, state_in;

   op_type            op_ff;
   logic [QUEUE_W-1:0] q_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic               from_list_ff;
   status_type         status_ff;

   logic                       rsp_valid_ff, rsp_valid_in;
   status_type                 rsp_status_ff;
   logic [RSP_TDATA_WIDTH-1:0] rsp_data_ff;

   logic                  issue, finish, out_free, ok_done;
   logic [QUEUE_W-1:0]    q_sel;
   logic                  q_nonempty;
   logic                  from_list, fill_ok;
   logic [SLOT_W-1:0]     slot_sel;
   status_type            status_sel;
   logic [SLOT_W-1:0]     rd_addr;
   logic                  data_we;
   logic [DATA_WIDTH-1:0] data_wval;
   logic                  next_we;
   logic [SLOT_W-1:0]     next_waddr;
   logic [PTR_W-1:0]      next_wval;
   logic signed [VALUE_WIDTH-1:0] value_s;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign issue    = (state_ff == BK_IDLE) && pop_valid;
   assign finish   = (state_ff == BK_DONE) && out_free;
   assign pop      = issue;
   assign ok_done  = status_ff == STATUS_OK;

   assign q_sel      = pop_op.qid_ok ? QUEUE_W'(pop_op.queue_id) : '0;
   assign q_nonempty = nonempty_ff[q_sel];
   assign from_list  = free_head_ff != NULL_PTR;
   assign fill_ok    = fill_ff != NULL_PTR;
   assign value_s    = $signed(pop_op.value);
   assign data_wval  = DATA_WIDTH'(value_s);

   // on issue: pick slot, decide status, start the table access
   always_comb begin
      slot_sel   = head_ff[q_sel];
      rd_addr    = head_ff[q_sel];
      status_sel = STATUS_OK;
      if (pop_op.mode == MODE_ENQ) begin
         slot_sel = from_list ? SLOT_W'(free_head_ff) : SLOT_W'(fill_ff);
         rd_addr  = SLOT_W'(free_head_ff);
         if (!pop_op.qid_ok || (!from_list && !fill_ok)) begin
            status_sel = STATUS_OVERFLOW;
         end
      end else begin
         if (!pop_op.qid_ok || !q_nonempty) begin
            status_sel = STATUS_UNDERFLOW;
         end
      end
   end

   assign data_we = issue && (pop_op.mode == MODE_ENQ) && (status_sel == STATUS_OK);

   always_comb begin
      next_we    = 1'b0;
      next_waddr = tail_ff[q_sel];
      next_wval  = PTR_W'(slot_sel);
      if (data_we && q_nonempty) begin
         next_we = 1'b1;
      end
      if (finish && ok_done && (op_ff.mode == MODE_DEQ)) begin
         next_we    = 1'b1;
         next_waddr = slot_ff;
         next_wval  = free_head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (data_we) begin
         data_mem[slot_sel] <= data_wval;
      end
      if (next_we) begin
         next_mem[next_waddr] <= next_wval;
      end
      if (issue) begin
         rd_data_ff <= data_mem[rd_addr];
         rd_next_ff <= next_mem[rd_addr];
      end
   end

   // on finish, once the output is free: commit pointer updates and load the result
   always_comb begin
      state_in     = state_ff;
      nonempty_in  = nonempty_ff;
      free_head_in = free_head_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         BK_IDLE: begin
            if (issue) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (finish) begin
               state_in     = BK_IDLE;
               rsp_valid_in = 1'b1;
               if (ok_done && (op_ff.mode == MODE_ENQ)) begin
                  nonempty_in[q_ff] = 1'b1;
                  if (from_list_ff) begin
                     free_head_in = rd_next_ff;
                  end else begin
                     fill_in = fill_ff + PTR_W'(1);
                  end
               end else if (ok_done) begin
                  if (head_ff[q_ff] == tail_ff[q_ff]) begin
                     nonempty_in[q_ff] = 1'b0;
                  end
                  free_head_in = PTR_W'(slot_ff);
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         nonempty_ff  <= '0;
         free_head_ff <= NULL_PTR;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nonempty_ff  <= nonempty_in;
         free_head_ff <= free_head_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         op_ff        <= pop_op;
         q_ff         <= q_sel;
         slot_ff      <= slot_sel;
         from_list_ff <= from_list;
         status_ff    <= status_sel;
      end
      if (finish && ok_done) begin
         if (op_ff.mode == MODE_ENQ) begin
            tail_ff[q_ff] <= slot_ff;
            if (!nonempty_ff[q_ff]) begin
               head_ff[q_ff] <= slot_ff;
            end
         end else if (head_ff[q_ff] != tail_ff[q_ff]) begin
            head_ff[q_ff] <= SLOT_W'(rd_next_ff);
         end
      end
      if (finish) begin
         rsp_status_ff <= status_ff;
         rsp_data_ff   <= (ok_done && (op_ff.mode == MODE_DEQ)) ?
                          RSP_TDATA_WIDTH'(rd_data_ff) : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ===== rtl/core/smq_checker.sv =====
module smq_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [smq_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,
   input logic [smq_pkg::STATUS_WIDTH-1:0]    rsp_tuser
);
   import smq_pkg::*;

   localparam int CNT_W = $clog2(MAX_OUTSTANDING + 1);

   logic [CNT_W-1:0] outstanding_ff, outstanding_in;
   logic             in_fire, out_fire;

   assign in_fire  = req_tvalid && req_tready;
   assign out_fire = rsp_tvalid && rsp_tready;

   // items accepted whose result is not yet taken
   always_comb begin
      outstanding_in = outstanding_ff;
      if (in_fire && !out_fire) begin
         outstanding_in = outstanding_ff + CNT_W'(1);
      end else if (out_fire && !in_fire) begin
         outstanding_in = outstanding_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != STATUS_OK) |-> rsp_tdata == '0)
      else $error("failed operation returned non-zero data");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> outstanding_ff != '0)
      else $error("result item without an accepted item");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= CNT_W'(MAX_OUTSTANDING))
      else $error("too many items in flight");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result item shown after reset");

endmodule

bind shared_buffer_multi_queue smq_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
